// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// ----- rtl/dtoi_pkg.sv -----
// ----------------------------------------------------------------------------
// dtoi_pkg
// Types and constants shared by the decimal text to integer unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtoi_pkg;

	// Fixed field widths.
	localparam int CHAR_W   = 8;
	localparam int VALUE_W  = 64;
	localparam int WCODE_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 2;

	// Character codes.
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [WCODE_W-1:0] WIDTH_CODE_RST  = 2'd3;
	localparam logic               SIGNED_MODE_RST = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	// One result item.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
	} result_t;

endpackage

// ----- rtl/dtoi_if.sv -----
// ----------------------------------------------------------------------------
// dtoi_if
// Valid/ready channels for the character stream and the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Character channel: one byte of the string per item.
interface dtoi_char_if;
	logic                        valid;
	logic                        ready;
	logic [dtoi_pkg::CHAR_W-1:0] character;
	logic                        last_char;

	modport source (output valid, output character, output last_char, input ready);
	modport sink (input valid, input character, input last_char, output ready);
endinterface

// Result channel: one parsed integer and its status per item.
interface dtoi_result_if;
	logic                         valid;
	logic                         ready;
	logic [dtoi_pkg::VALUE_W-1:0] value;
	logic [1:0]                   status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

// ----- rtl/decimal_text_to_integer_unit.sv -----
// ----------------------------------------------------------------------------
// decimal_text_to_integer_unit
// Parses a decimal string, one character per item, into an integer with an
// overflow and underflow check against the configured width and signedness.
// ----------------------------------------------------------------------------
// The unit takes one character per clock when not stalled and gives one
// result item for each character flagged as last. That character passes
// through the input register and then the result register, from which its
// result is handed off. The running value is updated by a single
// multiply-by-ten, add and compare between those two registers, so strings
// stream back to back at one character per cycle while the result side
// takes items. While a result waits in the output register, the character
// in the input register cannot move on, so the input stalls once both
// registers are full. Non-digits are skipped; a leading '-' makes the string
// negative. Configuration is written through cfg_we/cfg_index/cfg_wdata;
// the user must write it only while idle, as the block does not enforce it.
`timescale 1ns / 1ps

module decimal_text_to_integer_unit #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	dtoi_char_if.sink                        in_ch,
	dtoi_result_if.source                    out_ch,
	input  logic                             cfg_we,
	input  logic [dtoi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dtoi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	logic [dtoi_pkg::WCODE_W-1:0] width_code_q;
	logic                         signed_mode_q;

	logic                         valid_s1;
	logic [dtoi_pkg::CHAR_W-1:0]  char_s1;
	logic                         last_s1;
	logic                         adv;

	logic                         out_valid_q;
	dtoi_pkg::result_t            result;
	dtoi_pkg::result_t            result_q;

	logic [MAX_WIDTH-1:0]         mask;
	logic [MAX_WIDTH-1:0]         lim;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_code_q  <= dtoi_pkg::WIDTH_CODE_RST;
			signed_mode_q <= dtoi_pkg::SIGNED_MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dtoi_pkg::REG_WIDTH_CODE:  width_code_q  <= cfg_wdata;
				dtoi_pkg::REG_SIGNED_MODE: signed_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the result register can take a result.
	assign adv         = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			char_s1 <= in_ch.character;
			last_s1 <= in_ch.last_char;
		end
	end

	dtoi_limit #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_limit (
		.width_code (width_code_q),
		.signed_mode(signed_mode_q),
		.mask       (mask),
		.lim        (lim)
	);

	dtoi_accum #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.character  (char_s1),
		.last_char  (last_s1),
		.mask       (mask),
		.lim        (lim),
		.signed_mode(signed_mode_q),
		.result     (result)
	);

	// Result register: loaded by a last character, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			result_q <= result;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.value  = result_q.value;
	assign out_ch.status = result_q.status;

endmodule

// ----- rtl/dtoi_limit.sv -----
// ----------------------------------------------------------------------------
// dtoi_limit
// Derives the result mask and the largest allowed magnitude from the
// configured width and signedness.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtoi_limit #(
	parameter int MAX_WIDTH = 64
) (
	input  logic [dtoi_pkg::WCODE_W-1:0] width_code,
	input  logic                         signed_mode,
	output logic [MAX_WIDTH-1:0]         mask,
	output logic [MAX_WIDTH-1:0]         lim
);

	localparam int WW = $clog2(MAX_WIDTH + 1) + 1;

	logic [7:0]    nominal;
	logic [WW-1:0] width;

	// Nominal width is 8 << code, capped at the parameter.
	always_comb begin
		nominal = 8'(8'd8 << width_code);
		if (32'(nominal) > 32'(MAX_WIDTH)) begin
			width = WW'(MAX_WIDTH);
		end else begin
			width = WW'(nominal);
		end
	end

	// Each mask bit is set below the result width.
	always_comb begin
		for (int i = 0; i < MAX_WIDTH; i++) begin
			mask[i] = (32'(i) < 32'(width));
		end
	end

	// A signed result loses its top bit to the sign.
	assign lim = signed_mode ? (mask >> 1) : mask;

endmodule

// ----- rtl/dtoi_accum.sv -----
// ----------------------------------------------------------------------------
// dtoi_accum
// Running magnitude, sign and sticky too-large flag, with the result that
// the current character produces when it ends the string.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtoi_accum #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [dtoi_pkg::CHAR_W-1:0] character,
	input  logic                        last_char,
	input  logic [MAX_WIDTH-1:0]        mask,
	input  logic [MAX_WIDTH-1:0]        lim,
	input  logic                        signed_mode,
	output dtoi_pkg::result_t           result
);

	localparam int EW = MAX_WIDTH + 4;

	logic [MAX_WIDTH-1:0] mag_q;
	logic                 neg_q;
	logic                 big_q;
	logic                 start_q;

	logic                 is_digit;
	logic [3:0]           digit;
	logic [EW-1:0]        mag_ext;
	logic [EW-1:0]        cand;
	logic                 over;
	logic                 take;
	logic [MAX_WIDTH-1:0] mag_next;
	logic [MAX_WIDTH-1:0] neg_cand;
	logic [MAX_WIDTH-1:0] neg_old;
	logic [MAX_WIDTH-1:0] neg_val;
	logic                 neg_next;
	logic                 big_next;

	// Digit decode.
	assign is_digit = (character >= dtoi_pkg::CHAR_ZERO) && (character <= dtoi_pkg::CHAR_NINE);
	assign digit    = 4'(character - dtoi_pkg::CHAR_ZERO);

	// magnitude*10 + d, exact since the magnitude never exceeds the limit.
	assign mag_ext = EW'(mag_q);
	assign cand    = (mag_ext << 3) + (mag_ext << 1) + EW'(digit);
	assign over    = cand > EW'(lim);
	assign take    = is_digit && !big_q && !over;

	assign mag_next = take ? cand[MAX_WIDTH-1:0] : mag_q;
	assign big_next = big_q || (is_digit && over);
	assign neg_next = start_q ? (character == dtoi_pkg::CHAR_MINUS) : neg_q;

	// Both negations in parallel with the compare.
	assign neg_cand = -cand[MAX_WIDTH-1:0];
	assign neg_old  = -mag_q;
	assign neg_val  = take ? neg_cand : neg_old;

	// Result for a string that ends on this character.
	always_comb begin
		result.value  = '0;
		result.status = dtoi_pkg::STATUS_OK;
		if (neg_next) begin
			if (big_next || !signed_mode) begin
				result.status = dtoi_pkg::STATUS_UNDERFLOW;
			end else begin
				result.value = dtoi_pkg::VALUE_W'(neg_val & mask);
			end
		end else begin
			if (big_next) begin
				result.status = dtoi_pkg::STATUS_OVERFLOW;
			end else begin
				result.value = dtoi_pkg::VALUE_W'(mag_next & mask);
			end
		end
	end

	// String state; the last character returns it to the start condition.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q   <= '0;
			neg_q   <= 1'b0;
			big_q   <= 1'b0;
			start_q <= 1'b1;
		end else if (step) begin
			if (last_char) begin
				mag_q   <= '0;
				neg_q   <= 1'b0;
				big_q   <= 1'b0;
				start_q <= 1'b1;
			end else begin
				mag_q   <= mag_next;
				neg_q   <= neg_next;
				big_q   <= big_next;
				start_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/dtoi_checker.sv -----
// ----------------------------------------------------------------------------
// dtoi_checker
// Port-level checks on the decimal text to integer unit, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtoi_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [dtoi_pkg::VALUE_W-1:0] out_value,
	input logic [1:0]                   out_status
);

	// An empty result register never holds back the character stream.
	`ASSERT_IMPLIES(a_ready_when_out_empty, clk, arst_n, !out_valid, in_ready)

	// An error result carries a zero value.
	`ASSERT_IMPLIES(a_error_value_zero, clk, arst_n,
		out_valid && (out_status != dtoi_pkg::STATUS_OK), out_value == '0)

	// Status is one of the three defined codes.
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, out_valid,
		(out_status == dtoi_pkg::STATUS_OK) ||
		(out_status == dtoi_pkg::STATUS_OVERFLOW) ||
		(out_status == dtoi_pkg::STATUS_UNDERFLOW))

	// A stalled result item stays put.
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_value) && $stable(out_status))

endmodule

bind decimal_text_to_integer_unit dtoi_checker u_dtoi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_value (out_ch.value),
	.out_status(out_ch.status)
);
